/* sv/rce_pkg.sv */
// Shared constants, codes and handshake structs of the route cost evaluator.
package rce_pkg;

  localparam int unsigned EDGE_DEPTH = 4096;
  localparam int unsigned EDGE_AW    = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(EDGE_DEPTH + 1);

  localparam int unsigned ID_W    = 16;
  localparam int unsigned VAL_W   = 24;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned WGT_W   = 12;
  localparam int unsigned PROD_W  = WGT_W + SUM_W;
  localparam int unsigned SCORE_W = 45;
  localparam int unsigned ENDS_W  = 2 * ID_W;
  localparam int unsigned VALS_W  = 2 * VAL_W;
  localparam int unsigned FRAC_W  = 8;

  localparam logic [WGT_W-1:0]   WGT_RESET = WGT_W'(256);
  localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W - 1){1'b1}}};

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_NODE  = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_TIME_WEIGHT  = 1'b0,
    REG_RIDER_WEIGHT = 1'b1
  } reg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic take;
    logic restart;
    logic miss;
    logic scan_start;
    logic prev_from_in;
    logic prev_from_held;
    logic mul;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic invalid;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* sv/rce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/rce_ctrl.sv */
// Controller state machine of the route cost evaluator.
module rce_ctrl import rce_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic      first_node_i,
  input  logic      last_node_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MUL  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_e'(cmd_i))
            CMD_CLEAR: cmd_o.clear = 1'b1;
            CMD_LOAD:  cmd_o.load  = 1'b1;
            CMD_NODE: begin
              cmd_o.take = 1'b1;
              last_d     = last_node_i;
              if (first_node_i) begin
                cmd_o.restart      = 1'b1;
                cmd_o.prev_from_in = 1'b1;
                state_d            = last_node_i ? S_MUL : S_IDLE;
              end else if (stat_i.invalid || stat_i.cnt_zero) begin
                cmd_o.miss         = 1'b1;
                cmd_o.prev_from_in = 1'b1;
                state_d            = last_node_i ? S_MUL : S_IDLE;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          cmd_o.prev_from_held = 1'b1;
          state_d              = last_q ? S_MUL : S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

`ifndef SYNTH
  // A result is only written into the output register when it is free.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("emit while the output register is occupied");

  // Scan completion is only ever reported while the controller is scanning.
  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.scan_done |-> (state_q == S_SCAN))
    else $error("scan done outside of a scan");
`endif

endmodule

/* sv/rce_datapath.sv */
// Datapath of the route cost evaluator: edge table, scan, sums, score and output register.
module rce_datapath import rce_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_stat_t            stat_o,
  input  logic [ID_W-1:0]     edge_from_i,
  input  logic [ID_W-1:0]     edge_to_i,
  input  logic [VAL_W-1:0]    travel_time_i,
  input  logic [VAL_W-1:0]    riders_i,
  input  logic [ID_W-1:0]     node_id_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [WGT_W-1:0]    cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [SCORE_W-1:0] score_o,
  output logic [SUM_W-1:0]    total_time_o,
  output logic [SUM_W-1:0]    total_riders_o,
  output logic                route_invalid_o
);

  logic [WGT_W-1:0]  time_w_q, rider_w_q;
  logic [CNT_W-1:0]  edge_count_q;
  logic              full;
  logic              ram_we;

  logic [ID_W-1:0]   prev_q, node_q;
  logic [SUM_W-1:0]  sum_t_q, sum_r_q;
  logic              invalid_q;

  logic              scan_act_q, issued_all_q, rd_vld_q, rd_last_q;
  logic [CNT_W-1:0]  rd_idx_q;
  logic              issue, issue_last, hit, miss_end, scan_done;
  logic [ENDS_W-1:0] ends_rdata;
  logic [VALS_W-1:0] vals_rdata;

  logic [SUM_W:0]    add_t, add_r;
  logic [PROD_W-1:0] prod_t_q, prod_r_q;
  logic signed [SCORE_W-1:0] diff, score_floor;

  logic              out_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_w_q  <= WGT_RESET;
      rider_w_q <= WGT_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TIME_WEIGHT:  time_w_q  <= cfg_data_i;
        REG_RIDER_WEIGHT: rider_w_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Edge table.
  assign full   = (edge_count_q == CNT_W'(EDGE_DEPTH));
  assign ram_we = cmd_i.load && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q <= '0;
    end else if (cmd_i.clear) begin
      edge_count_q <= '0;
    end else if (ram_we) begin
      edge_count_q <= edge_count_q + CNT_W'(1);
    end
  end

  assign issue      = scan_act_q && !issued_all_q;
  assign issue_last = (rd_idx_q == edge_count_q - CNT_W'(1));

  rce_ram #(.WIDTH(ENDS_W), .DEPTH(EDGE_DEPTH)) u_ends_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (edge_count_q[EDGE_AW-1:0]),
    .wdata_i ({edge_from_i, edge_to_i}),
    .re_i    (issue),
    .raddr_i (rd_idx_q[EDGE_AW-1:0]),
    .rdata_o (ends_rdata)
  );

  rce_ram #(.WIDTH(VALS_W), .DEPTH(EDGE_DEPTH)) u_vals_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (edge_count_q[EDGE_AW-1:0]),
    .wdata_i ({travel_time_i, riders_i}),
    .re_i    (issue),
    .raddr_i (rd_idx_q[EDGE_AW-1:0]),
    .rdata_o (vals_rdata)
  );

  // Scan: one read issued per cycle, compared in the next cycle.
  assign hit       = rd_vld_q && (ends_rdata == {prev_q, node_q});
  assign miss_end  = rd_vld_q && !hit && rd_last_q;
  assign scan_done = hit || miss_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_act_q   <= 1'b0;
      issued_all_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_last_q    <= 1'b0;
      rd_idx_q     <= '0;
    end else if (cmd_i.scan_start) begin
      scan_act_q   <= 1'b1;
      issued_all_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
    end else if (scan_act_q) begin
      if (scan_done) begin
        scan_act_q <= 1'b0;
        rd_vld_q   <= 1'b0;
      end else begin
        rd_vld_q  <= issue;
        rd_last_q <= issue_last;
        if (issue) begin
          if (issue_last) begin
            issued_all_q <= 1'b1;
          end else begin
            rd_idx_q <= rd_idx_q + CNT_W'(1);
          end
        end
      end
    end
  end

  // Route state and saturating sums.
  assign add_t = {1'b0, sum_t_q} + (SUM_W + 1)'(vals_rdata[VALS_W-1:VAL_W]);
  assign add_r = {1'b0, sum_r_q} + (SUM_W + 1)'(vals_rdata[VAL_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      node_q    <= '0;
      sum_t_q   <= '0;
      sum_r_q   <= '0;
      invalid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        node_q <= node_id_i;
      end
      if (cmd_i.prev_from_in) begin
        prev_q <= node_id_i;
      end else if (cmd_i.prev_from_held) begin
        prev_q <= node_q;
      end
      if (cmd_i.restart || cmd_i.emit) begin
        sum_t_q   <= '0;
        sum_r_q   <= '0;
        invalid_q <= 1'b0;
      end else if (cmd_i.miss || miss_end) begin
        invalid_q <= 1'b1;
      end else if (hit) begin
        sum_t_q <= add_t[SUM_W] ? {SUM_W{1'b1}} : add_t[SUM_W-1:0];
        sum_r_q <= add_r[SUM_W] ? {SUM_W{1'b1}} : add_r[SUM_W-1:0];
      end
    end
  end

  // Score: register both products, then subtract and floor-shift into the output.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_t_q <= PROD_W'(time_w_q) * PROD_W'(sum_t_q);
      prod_r_q <= PROD_W'(rider_w_q) * PROD_W'(sum_r_q);
    end
  end

  assign diff        = $signed({1'b0, prod_t_q}) - $signed({1'b0, prod_r_q});
  assign score_floor = diff >>> FRAC_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      route_invalid_o <= invalid_q;
      score_o         <= invalid_q ? $signed(SCORE_MAX) : score_floor;
      total_time_o    <= invalid_q ? '0 : sum_t_q;
      total_riders_o  <= invalid_q ? '0 : sum_r_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.cnt_zero  = (edge_count_q == '0);
  assign stat_o.invalid   = invalid_q;
  assign stat_o.scan_done = scan_done;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

`ifndef SYNTH
  // The table never holds more edges than its depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_count_q <= CNT_W'(EDGE_DEPTH))
    else $error("edge count beyond table depth");

  // A compared entry always lies inside the loaded part of the table.
  a_read_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (rd_idx_q < edge_count_q))
    else $error("scan read past the loaded edges");

  // An invalid route always leaves with the maximum score and zero totals.
  a_invalid_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && invalid_q) |=>
      (score_o == $signed(SCORE_MAX) && total_time_o == '0 && total_riders_o == '0))
    else $error("invalid route result malformed");
`endif

endmodule

/* sv/route_cost_evaluator.sv */
// Top level of the route cost evaluator: controller, datapath and ports.
// Clear, load and unused-command beats, first nodes, and nodes of an invalid route or an
// empty table need no scan. Other nodes scan from entry zero at one table read a cycle,
// each compared in the next cycle, until a match or the last loaded entry.
// A last node then passes the multiply and emit states; emit waits for a free output register.
// Reset clears edge count, route state and output valid and sets both weights to 1.0.
module route_cost_evaluator import rce_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port: index 0 is time_weight, index 1 is rider_weight.
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [WGT_W-1:0]          cfg_data_i,
  // Input beat.
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                cmd_i,
  input  logic [ID_W-1:0]           edge_from_i,
  input  logic [ID_W-1:0]           edge_to_i,
  input  logic [VAL_W-1:0]          travel_time_i,
  input  logic [VAL_W-1:0]          riders_i,
  input  logic [ID_W-1:0]           node_id_i,
  input  logic                      first_node_i,
  input  logic                      last_node_i,
  // Result beat.
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SCORE_W-1:0] score_o,
  output logic [SUM_W-1:0]          total_time_o,
  output logic [SUM_W-1:0]          total_riders_o,
  output logic                      route_invalid_o
);

  // The controller decodes each accepted beat and sequences scans and scoring;
  // the datapath owns every register and memory that holds data.
  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  rce_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .first_node_i (first_node_i),
    .last_node_i  (last_node_i),
    .stat_i       (dp_stat),
    .cmd_o        (ctrl_cmd)
  );

  // The output register in the datapath lets the next input beat be accepted while a
  // finished result still waits; only a second result stalls until it drains.
  rce_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .stat_o          (dp_stat),
    .edge_from_i     (edge_from_i),
    .edge_to_i       (edge_to_i),
    .travel_time_i   (travel_time_i),
    .riders_i        (riders_i),
    .node_id_i       (node_id_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .score_o         (score_o),
    .total_time_o    (total_time_o),
    .total_riders_o  (total_riders_o),
    .route_invalid_o (route_invalid_o)
  );

endmodule
